// File: hdl/psbk_pkg.sv
// psbk_pkg: shared widths, types and constants for the grouped record sorter.
// No dependencies; every other file in hdl/ uses it by scoped names.
package psbk_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

    localparam int YEAR_W   = 12;
    localparam int TARGET_W = 11;
    localparam int MEAN_W   = 16;
    localparam int INDEX_W  = 6;
    localparam int KEY_W    = MEAN_W + 1;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(2022);

    // register select is paddr[2] (word index)
    localparam logic REG_TARGET_YEAR = 1'b0;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              matched;
        logic              last;
    } t_work;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [MEAN_W-1:0]  mean;
        logic               matched;
    } t_cell;

    typedef enum logic [1:0] {
        ST_INSERT = 2'b01,
        ST_DRAIN  = 2'b10
    } t_state;

    // sort key: match flag above the mean, larger goes first
    function automatic logic [KEY_W-1:0] cell_key(input t_cell c);
        cell_key = {c.matched, c.mean};
    endfunction

endpackage

// File: hdl/partition_sort_by_key_match.sv
// partition_sort_by_key_match: top level of the grouped descending record sorter.
// Depends on psbk_pkg, psbk_regs, psbk_front, psbk_fifo, psbk_sorter.
//
//  channel   handshake           payload
//  records   push / full         i_record_year, i_record_mean, i_last_record
//  results   pop / empty         o_record_index, o_year_matched, o_final_result
//  config    psel/penable/pwrite target_year at paddr 0 (pwdata/prdata, pready tied high)
//
// Records enter the insertion chain one per cycle while not draining, dropped once 64 are stored;
// a 4-entry queue sits between the classifying front and the chain.
// The record with the last mark starts a drain of N results (N = stored records),
// one per cycle while pop keeps up, through the output register; no records enter the chain meanwhile.
// Synchronous active-low reset; no clearing pass, the stored count alone marks the valid cells.
// Either side may stall freely: full backs up into the queue, pop gaps hold the drain.
module partition_sort_by_key_match (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [psbk_pkg::YEAR_W-1:0]    i_record_year,
    input  logic [psbk_pkg::MEAN_W-1:0]    i_record_mean,
    input  logic                           i_last_record,
    output logic                           empty,
    input  logic                           pop,
    output logic [psbk_pkg::INDEX_W-1:0]   o_record_index,
    output logic                           o_year_matched,
    output logic                           o_final_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [psbk_pkg::ADDR_W-1:0]    paddr,
    input  logic [psbk_pkg::DATA_W-1:0]    pwdata,
    output logic [psbk_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    logic [psbk_pkg::TARGET_W-1:0] w_target_year;
    logic                          w_fifo_full;
    logic                          w_wr_en;
    psbk_pkg::t_work               w_wr_data;
    logic                          w_fifo_valid;
    psbk_pkg::t_work               w_rd_data;
    logic                          w_take;

    psbk_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_target_year (w_target_year)
    );

    psbk_front u_front (
        .i_push        (push),
        .i_record_year (i_record_year),
        .i_record_mean (i_record_mean),
        .i_last_record (i_last_record),
        .i_target_year (w_target_year),
        .i_fifo_full   (w_fifo_full),
        .o_full        (full),
        .o_wr_en       (w_wr_en),
        .o_wr_data     (w_wr_data)
    );

    psbk_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_data (w_wr_data),
        .o_full    (w_fifo_full),
        .o_valid   (w_fifo_valid),
        .o_rd_data (w_rd_data),
        .i_rd_en   (w_take)
    );

    psbk_sorter u_sorter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_fifo_valid),
        .i_data         (w_rd_data),
        .o_take         (w_take),
        .o_record_index (o_record_index),
        .o_year_matched (o_year_matched),
        .o_final_result (o_final_result),
        .o_empty        (empty),
        .i_pop          (pop)
    );

endmodule

// File: hdl/psbk_regs.sv
// psbk_regs: APB-style configuration register file (target year).
// Depends on psbk_pkg.
module psbk_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [psbk_pkg::ADDR_W-1:0]    paddr,
    input  logic [psbk_pkg::DATA_W-1:0]    pwdata,
    output logic [psbk_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output logic [psbk_pkg::TARGET_W-1:0]  o_target_year
);

    logic [psbk_pkg::TARGET_W-1:0] r_target_year;
    logic                          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_year <= psbk_pkg::TARGET_RESET;
        end else if (w_wr && (paddr[2] == psbk_pkg::REG_TARGET_YEAR)) begin
            r_target_year <= pwdata[psbk_pkg::TARGET_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == psbk_pkg::REG_TARGET_YEAR) begin
            prdata = psbk_pkg::DATA_W'(r_target_year);
        end else begin
            prdata = '0;
        end
    end

    assign o_target_year = r_target_year;

endmodule

// File: hdl/psbk_front.sv
// psbk_front: accepts records and classifies them against the target year.
// Depends on psbk_pkg; feeds psbk_fifo.
module psbk_front (
    input  logic                           i_push,
    input  logic [psbk_pkg::YEAR_W-1:0]    i_record_year,
    input  logic [psbk_pkg::MEAN_W-1:0]    i_record_mean,
    input  logic                           i_last_record,
    input  logic [psbk_pkg::TARGET_W-1:0]  i_target_year,
    input  logic                           i_fifo_full,
    output logic                           o_full,
    output logic                           o_wr_en,
    output psbk_pkg::t_work                o_wr_data
);

    logic w_match;

    // full 12-bit compare: years above 2047 never match
    assign w_match = (i_record_year == {1'b0, i_target_year});

    assign o_full            = i_fifo_full;
    assign o_wr_en           = i_push && !i_fifo_full;
    assign o_wr_data.mean    = i_record_mean;
    assign o_wr_data.matched = w_match;
    assign o_wr_data.last    = i_last_record;

endmodule

// File: hdl/psbk_fifo.sv
// psbk_fifo: short queue of classified records between front and sorter.
// Depends on psbk_pkg.
module psbk_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  psbk_pkg::t_work  i_wr_data,
    output logic             o_full,
    output logic             o_valid,
    output psbk_pkg::t_work  o_rd_data,
    input  logic             i_rd_en
);

    psbk_pkg::t_work                 r_mem [psbk_pkg::FIFO_DEPTH];
    logic [psbk_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [psbk_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [psbk_pkg::FIFO_PTR_W:0]   r_level;
    logic                            w_wr;
    logic                            w_rd;

    assign o_full    = (r_level == (psbk_pkg::FIFO_PTR_W+1)'(psbk_pkg::FIFO_DEPTH));
    assign o_valid   = (r_level != '0);
    assign w_wr      = i_wr_en && !o_full;
    assign w_rd      = i_rd_en && o_valid;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_level <= r_level + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

// File: hdl/psbk_sorter.sv
// psbk_sorter: insertion chain of sorted cells plus result drain and output register.
// Depends on psbk_pkg; pulls transactions from psbk_fifo.
module psbk_sorter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  psbk_pkg::t_work               i_data,
    output logic                          o_take,
    output logic [psbk_pkg::INDEX_W-1:0]  o_record_index,
    output logic                          o_year_matched,
    output logic                          o_final_result,
    output logic                          o_empty,
    input  logic                          i_pop
);

    localparam int N = psbk_pkg::MAX_RECORDS;

    psbk_pkg::t_cell                r_cell [N];
    logic [N-1:0]                   w_keep;
    psbk_pkg::t_cell                w_new;
    logic [psbk_pkg::KEY_W-1:0]     w_key_new;
    psbk_pkg::t_state               r_state;
    logic [psbk_pkg::CNT_W-1:0]     r_count;
    logic [psbk_pkg::INDEX_W-1:0]   r_arrival;
    logic                           r_out_valid;
    logic [psbk_pkg::INDEX_W-1:0]   r_out_index;
    logic                           r_out_match;
    logic                           r_out_final;
    logic                           w_take;
    logic                           w_room;
    logic                           w_ins;
    logic                           w_load;

    assign w_new.index   = r_arrival;
    assign w_new.mean    = i_data.mean;
    assign w_new.matched = i_data.matched;
    assign w_key_new     = psbk_pkg::cell_key(w_new);

    assign w_take = (r_state == psbk_pkg::ST_INSERT) && i_valid;
    assign w_room = (r_count != psbk_pkg::CNT_W'(N));
    assign w_ins  = w_take && w_room;
    assign w_load = (r_state == psbk_pkg::ST_DRAIN) && (!r_out_valid || i_pop);
    assign o_take = w_take;

    // each cell stays put while its key is not below the new one (ties keep order)
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign w_keep[g] = (psbk_pkg::CNT_W'(g) < r_count) &&
                               (psbk_pkg::cell_key(r_cell[g]) >= w_key_new);

            always_ff @(posedge i_clk) begin
                if (w_ins) begin
                    if (!w_keep[g]) begin
                        if (g == 0) begin
                            r_cell[g] <= w_new;
                        end else if (w_keep[(g > 0) ? g - 1 : 0]) begin
                            r_cell[g] <= w_new;
                        end else begin
                            r_cell[g] <= r_cell[(g > 0) ? g - 1 : 0];
                        end
                    end
                end else if (w_load) begin
                    // drain shifts the list toward the head
                    r_cell[g] <= r_cell[(g < N - 1) ? g + 1 : g];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psbk_pkg::ST_INSERT;
            r_count     <= '0;
            r_arrival   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                psbk_pkg::ST_INSERT: begin
                    if (w_take) begin
                        if (w_room) begin
                            r_count   <= r_count + 1'b1;
                            r_arrival <= r_arrival + 1'b1;
                        end
                        if (i_data.last) begin
                            r_state <= psbk_pkg::ST_DRAIN;
                        end
                    end
                end
                psbk_pkg::ST_DRAIN: begin
                    if (w_load) begin
                        r_count <= r_count - 1'b1;
                        if (r_count == psbk_pkg::CNT_W'(1)) begin
                            r_state   <= psbk_pkg::ST_INSERT;
                            r_arrival <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= psbk_pkg::ST_INSERT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_index <= r_cell[0].index;
            r_out_match <= r_cell[0].matched;
            r_out_final <= (r_count == psbk_pkg::CNT_W'(1));
        end
    end

    assign o_record_index = r_out_index;
    assign o_year_matched = r_out_match;
    assign o_final_result = r_out_final;
    assign o_empty        = !r_out_valid;

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psbk_pkg::ST_DRAIN) |-> (r_count != '0))
        else $error("drain state with no stored records");

    a_final_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_count == psbk_pkg::CNT_W'(1))) |=>
        ((r_state == psbk_pkg::ST_INSERT) && (r_count == '0) && o_final_result))
        else $error("last result did not close the run");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == psbk_pkg::ST_INSERT) && (r_count >= psbk_pkg::CNT_W'(2))) |->
        (psbk_pkg::cell_key(r_cell[0]) >= psbk_pkg::cell_key(r_cell[1])))
        else $error("head cells out of order");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_room) |=> (r_count == psbk_pkg::CNT_W'(N)))
        else $error("dropped record changed the count");

endmodule
